>>> rtl/core/ax25_afp_pkg.sv
// Shared types and constants for the AX.25 address field parser.
package ax25_afp_pkg;

	localparam int ADDR_BYTES = 7;
	localparam int ADDR_W     = 8 * ADDR_BYTES;
	localparam int OUT_DATA_W = 80;

	typedef enum logic [2:0] {
		PH_COLLECT = 3'b001,
		PH_DONE    = 3'b010,
		PH_ERROR   = 3'b100
	} phase_t;

	localparam logic [1:0] KIND_DEST   = 2'd0;
	localparam logic [1:0] KIND_SOURCE = 2'd1;
	localparam logic [1:0] KIND_REPEAT = 2'd2;

	localparam logic [1:0] ROLE_NONE     = 2'd0;
	localparam logic [1:0] ROLE_COMMAND  = 2'd1;
	localparam logic [1:0] ROLE_RESPONSE = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_SHORT     = 2'd1;
	localparam logic [1:0] STAT_TOO_MANY  = 2'd2;

	localparam logic [7:0] BIT_C_H  = 8'h80;
	localparam logic [7:0] BIT_RR   = 8'h20;
	localparam logic [7:0] BIT_EXT  = 8'h01;

	localparam logic signed [3:0] LAST_RPT_NONE = -4'sd1;

	typedef struct packed {
		logic [ADDR_W-1:0]  address;
		logic [1:0]         kind;
		logic [2:0]         repeater_index;
		logic               repeated;
		logic [1:0]         role;
		logic               dama;
		logic signed [3:0]  last_repeated;
		logic [6:0]         header_length;
		logic [1:0]         status;
		logic               last;
	} res_t;

endpackage

>>> rtl/core/ax25_address_field_parser_core.sv
// Top level of the AX.25 address field parser: byte stream in, address words out.
//
// Usage:
// The slave channel takes one frame byte per word in s_tdata, with s_tlast on
// the final byte of the frame. Bytes are grouped into 7-byte addresses
// (destination, source, repeaters); the field ends at the first address from
// the source on whose last byte has the extension bit set.
// The master channel gives one word per completed address, or one error word
// when the frame ends inside an address. m_tuser carries the address kind and
// m_tlast marks the final word of the field or an error.
// A result is registered and appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle while s_tready is high; the per-byte counter and
// shift register update together and a single output register holds the result.
// A stalled receiver holds the output register; s_tready drops only while that
// register is full and not being taken.
// Reset clears all counters, the flags and the output valid. An accepted
// s_tlast returns the parser to its reset state for the next frame.
module ax25_address_field_parser_core
	import ax25_afp_pkg::*;
#(
	parameter int MAX_REPEATERS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] frame_byte
	input  logic                  s_tlast,   // frame_end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // address[55:0], repeater_index[58:56],
	                                         // repeated[59], role[61:60], dama[62],
	                                         // last_repeated[66:63], header_length[73:67],
	                                         // status[75:74], zero[79:76]
	output logic [1:0]            m_tuser,   // kind[1:0]
	output logic                  m_tlast    // last
);

	localparam logic [3:0] ERR_IDX = 4'(MAX_REPEATERS + 1);

	logic [2:0]        byte_cnt_q;
	logic [3:0]        addr_cnt_q;
	logic [ADDR_W-1:0] shift_q;
	logic [1:0]        role_q;
	logic              dama_q;
	logic signed [3:0] last_rpt_q;
	phase_t            phase_q;

	logic              out_valid_q;
	res_t              out_q;

	logic              in_acc;
	logic              emit;
	res_t              res;
	logic [ADDR_W-1:0] shift_n;
	logic              addr_done;
	logic [1:0]        role_n;
	logic              dama_n;
	logic signed [3:0] last_rpt_n;
	phase_t            phase_n;
	logic [7:0]        b;

	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign b        = s_tdata;
	assign shift_n  = {shift_q[ADDR_W-9:0], b};
	assign addr_done = (byte_cnt_q == 3'(ADDR_BYTES - 1));

	always_comb begin
		res        = '0;
		emit       = 1'b0;
		role_n     = role_q;
		dama_n     = dama_q;
		last_rpt_n = last_rpt_q;
		phase_n    = phase_q;
		if (phase_q == PH_COLLECT) begin
			if (addr_done) begin
				emit = 1'b1;
				res.address = shift_n;
				case (addr_cnt_q)
					4'd0: begin
						res.kind = KIND_DEST;
						if ((b & BIT_C_H) != 8'd0)
							role_n = ROLE_COMMAND;
					end
					4'd1: begin
						res.kind = KIND_SOURCE;
						if ((b & BIT_C_H) != 8'd0)
							role_n = ROLE_RESPONSE;
						dama_n = ((b & BIT_RR) == 8'd0);
					end
					default: begin
						res.kind           = KIND_REPEAT;
						res.repeater_index = 3'(addr_cnt_q - 4'd2);
						res.repeated       = b[7];
						if (b[7])
							last_rpt_n = signed'({1'b0, 3'(addr_cnt_q - 4'd2)});
					end
				endcase
				if (addr_cnt_q != 4'd0) begin
					res.role = role_n;
					res.dama = dama_n;
				end
				res.last_repeated = last_rpt_n;
				if (addr_cnt_q != 4'd0 && (b & BIT_EXT) != 8'd0) begin
					res.header_length = 7'(({3'd0, addr_cnt_q} + 7'd1) * 7'd7);
					res.last          = 1'b1;
					phase_n           = PH_DONE;
				end else if (addr_cnt_q >= ERR_IDX) begin
					res.status = STAT_TOO_MANY;
					res.last   = 1'b1;
					phase_n    = PH_ERROR;
				end else if (s_tlast) begin
					res.status = STAT_SHORT;
					res.last   = 1'b1;
				end
			end else if (s_tlast) begin
				// frame ended inside an address
				emit              = 1'b1;
				res.last_repeated = last_rpt_q;
				res.status        = STAT_SHORT;
				res.last          = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			addr_cnt_q <= '0;
			shift_q    <= '0;
			role_q     <= ROLE_NONE;
			dama_q     <= 1'b0;
			last_rpt_q <= LAST_RPT_NONE;
			phase_q    <= PH_COLLECT;
		end else if (in_acc) begin
			if (s_tlast) begin
				byte_cnt_q <= '0;
				addr_cnt_q <= '0;
				shift_q    <= '0;
				role_q     <= ROLE_NONE;
				dama_q     <= 1'b0;
				last_rpt_q <= LAST_RPT_NONE;
				phase_q    <= PH_COLLECT;
			end else if (phase_q == PH_COLLECT) begin
				shift_q    <= shift_n;
				role_q     <= role_n;
				dama_q     <= dama_n;
				last_rpt_q <= last_rpt_n;
				phase_q    <= phase_n;
				if (addr_done) begin
					byte_cnt_q <= '0;
					addr_cnt_q <= addr_cnt_q + 4'd1;
				end else begin
					byte_cnt_q <= byte_cnt_q + 3'd1;
				end
			end
		end
	end

	// Output register: load a new word, or drop the old one once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {4'd0, out_q.status, out_q.header_length, out_q.last_repeated,
		out_q.dama, out_q.role, out_q.repeated, out_q.repeater_index, out_q.address};

	a_frame_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tlast |=> byte_cnt_q == 3'd0 && addr_cnt_q == 4'd0
			&& phase_q == PH_COLLECT)
		else $error("parser state not cleared after frame end");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[75:74] != STAT_OK |-> m_tlast)
		else $error("error word without last");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COLLECT |-> addr_cnt_q <= ERR_IDX)
		else $error("address count past repeater limit while collecting");

	a_no_emit_after_field: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && phase_q != PH_COLLECT |=> !(out_valid_q && !$past(out_valid_q)))
		else $error("word emitted after field end or error");

endmodule

>>> sim/ax25_afp_checker.sv
`timescale 1ns / 1ps
// Checker for the AX.25 address field parser: predicts address words and compares them.
module ax25_afp_checker
	import ax25_afp_pkg::*;
#(
	parameter int MAX_RPT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [1:0]            m_tuser,
	input  logic                  m_tlast,
	output int                    fail_count,
	output int                    pending
);

	logic [2:0]        byte_pos;
	logic [3:0]        addr_idx;
	logic [ADDR_W-1:0] addr_sr;
	logic [1:0]        role_acc;
	logic              dama_acc;
	logic signed [3:0] last_rpt;
	phase_t            parse_phase;
	res_t              addr_results[$];
	int                mismatches = 0;

	task automatic clear_parser();
		byte_pos    = '0;
		addr_idx    = '0;
		addr_sr     = '0;
		role_acc    = ROLE_NONE;
		dama_acc    = 1'b0;
		last_rpt    = LAST_RPT_NONE;
		parse_phase = PH_COLLECT;
	endtask

	// Advance the parser by one frame byte and queue the address word it completes.
	task automatic parse_byte(input logic [7:0] b, input logic fin);
		res_t       r;
		logic [3:0] idx;
		r = '0;
		if (parse_phase == PH_COLLECT) begin
			addr_sr = {addr_sr[ADDR_W-9:0], b};
			if (byte_pos == 3'(ADDR_BYTES - 1)) begin
				idx      = addr_idx;
				byte_pos = '0;
				r.address = addr_sr;
				if (idx == 4'd0) begin
					if ((b & BIT_C_H) != '0)
						role_acc = ROLE_COMMAND;
					r.kind = KIND_DEST;
				end else if (idx == 4'd1) begin
					if ((b & BIT_C_H) != '0)
						role_acc = ROLE_RESPONSE;
					dama_acc = ((b & BIT_RR) == '0);
					r.kind = KIND_SOURCE;
				end else begin
					r.kind           = KIND_REPEAT;
					r.repeater_index = 3'(idx - 4'd2);
					r.repeated       = ((b & BIT_C_H) != '0);
					if (r.repeated)
						last_rpt = {1'b0, r.repeater_index};
				end
				addr_idx = addr_idx + 4'd1;
				if (idx != 4'd0) begin
					r.role = role_acc;
					r.dama = dama_acc;
				end
				r.last_repeated = last_rpt;
				// extension bit ends the field, checked from the source on
				if (idx != 4'd0 && (b & BIT_EXT) != '0) begin
					r.header_length = 7'(ADDR_BYTES * (int'(idx) + 1));
					r.last          = 1'b1;
					parse_phase     = PH_DONE;
				end else if (idx != 4'd0 && int'(idx) - 1 >= MAX_RPT) begin
					r.status    = STAT_TOO_MANY;
					r.last      = 1'b1;
					parse_phase = PH_ERROR;
				end else if (fin) begin
					r.status = STAT_SHORT;
					r.last   = 1'b1;
				end
				addr_results.push_back(r);
			end else begin
				byte_pos = byte_pos + 3'd1;
				if (fin) begin
					r.last_repeated = last_rpt;
					r.status        = STAT_SHORT;
					r.last          = 1'b1;
					addr_results.push_back(r);
				end
			end
		end
		if (fin)
			clear_parser();
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			clear_parser();
			addr_results.delete();
		end else begin
			// compare first: a word leaving now never comes from the byte entering now
			if (m_tvalid && m_tready) begin
				if (addr_results.size() == 0) begin
					$error("unexpected address word: tdata 0x%0h", m_tdata);
					mismatches++;
				end else begin
					want = addr_results.pop_front();
					check_field("address", 64'(want.address), 64'(m_tdata[55:0]));
					check_field("kind", 64'(want.kind), 64'(m_tuser));
					check_field("repeater_index", 64'(want.repeater_index),
						64'(m_tdata[58:56]));
					check_field("repeated", 64'(want.repeated), 64'(m_tdata[59]));
					check_field("role", 64'(want.role), 64'(m_tdata[61:60]));
					check_field("dama", 64'(want.dama), 64'(m_tdata[62]));
					check_field("last_repeated", 64'($unsigned(want.last_repeated)),
						64'(m_tdata[66:63]));
					check_field("header_length", 64'(want.header_length),
						64'(m_tdata[73:67]));
					check_field("status", 64'(want.status), 64'(m_tdata[75:74]));
					check_field("pad", '0, 64'(m_tdata[79:76]));
					check_field("last", 64'(want.last), 64'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
		end
		pending    <= addr_results.size();
		fail_count <= mismatches;
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the AX.25 address field parser: clock, reset, frame stimulus, verdict.
module tb_top
	import ax25_afp_pkg::*;
();

	localparam int MAX_RPT     = 8;
	localparam int BYTE_TARGET = 1650;
	localparam int STALL_LIMIT = 2000;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata  = '0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	int                    fail_count;
	int                    pending;

	int         parsed_bytes = 0;
	int         idle_pct     = 0;
	int         stall_pct    = 0;
	int         stall_left   = 0;
	int         idle_cycles  = 0;
	logic       steady_tail  = 1'b0;
	logic [7:0] frame_q[$];

	ax25_address_field_parser_core #(
		.MAX_REPEATERS(MAX_RPT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	ax25_afp_checker #(
		.MAX_RPT(MAX_RPT)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	// Receiver: stall in bursts of random length, never in the tail.
	always @(posedge clk) begin
		if (steady_tail) begin
			stall_left <= 0;
			m_tready   <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_left <= $urandom_range(7);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("ax25_address_field_parser_core verification failed");
			$finish;
		end
	end

	task automatic send_word(input logic [7:0] b, input logic fin);
		if (!steady_tail && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			send_word(frame_q[i], i == frame_q.size() - 1);
		frame_q.delete();
	endtask

	// Append one address: six random bytes, then an SSID byte with the chosen extension bit.
	task automatic push_address(input logic ext);
		logic [7:0] ssid;
		repeat (ADDR_BYTES - 1)
			frame_q.push_back(8'($urandom));
		ssid = 8'($urandom);
		ssid = ext ? (ssid | BIT_EXT) : (ssid & ~BIT_EXT);
		frame_q.push_back(ssid);
	endtask

	task automatic random_frame();
		int pick;
		int nrep;
		int hdr;
		int cut;
		pick = $urandom_range(99);
		nrep = $urandom_range(MAX_RPT);
		// destination extension bit is never looked at
		push_address(1'($urandom_range(1)));
		if (pick < 12) begin
			// run the path past the repeater limit without an extension bit
			repeat (MAX_RPT + 1)
				push_address(1'b0);
			hdr = frame_q.size();
			repeat ($urandom_range(1, 10))
				frame_q.push_back(8'($urandom));
		end else if (pick < 20) begin
			frame_q.delete();
			repeat ($urandom_range(1, 40))
				frame_q.push_back(8'($urandom));
			hdr = frame_q.size();
		end else begin
			push_address(nrep == 0);
			for (int i = 1; i <= nrep; i++)
				push_address(i == nrep);
			hdr = frame_q.size();
			if (pick < 36) begin
				// truncate, half the time right on an address boundary
				if ($urandom_range(1))
					cut = ADDR_BYTES * $urandom_range(1, frame_q.size() / ADDR_BYTES - 1);
				else
					cut = $urandom_range(1, frame_q.size() - 1);
				while (frame_q.size() > cut)
					void'(frame_q.pop_back());
				hdr = cut;
			end else begin
				repeat ($urandom_range(0, 5))
					frame_q.push_back(8'($urandom));
			end
		end
		parsed_bytes += hdr;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// command frame: all-ones destination, source of zeros with only the extension bit set ending the field, then payload
		repeat (ADDR_BYTES) frame_q.push_back(8'hFF);
		repeat (ADDR_BYTES - 1) frame_q.push_back(8'h00);
		frame_q.push_back(BIT_EXT);
		frame_q.push_back(8'hFF);
		frame_q.push_back(8'h00);
		send_frame();
		// frame ends right after the destination
		repeat (ADDR_BYTES) frame_q.push_back(8'h00);
		send_frame();
		// frame ends inside the first address
		frame_q.push_back(8'hFF);
		send_frame();

		while (parsed_bytes < BYTE_TARGET) begin
			steady_tail <= parsed_bytes > BYTE_TARGET * 85 / 100;
			idle_pct     = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
			stall_pct   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
			random_frame();
			send_frame();
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ax25_address_field_parser_core verification clean");
		else
			$display("ax25_address_field_parser_core verification failed");
		$finish;
	end

endmodule
